// ===== src/nms_pkg.sv =====
// Shared types, register codes and direction sector decode for the NMS block.
`default_nettype none
package nms_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 4095;

	localparam int CFG_DATA_W  = 12;
	localparam int CFG_INDEX_W = 1;
	localparam int MAG_W       = 8;
	localparam int DIR_W       = 10;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam int WIDTH_RST  = 640;
	localparam int HEIGHT_RST = 480;
	localparam int MIN_DIM    = 3;

	// sector bounds in half-degrees
	localparam logic [DIR_W-1:0] DIR_22P5  = 10'd45;
	localparam logic [DIR_W-1:0] DIR_67P5  = 10'd135;
	localparam logic [DIR_W-1:0] DIR_112P5 = 10'd225;
	localparam logic [DIR_W-1:0] DIR_157P5 = 10'd315;
	localparam logic [DIR_W-1:0] DIR_202P5 = 10'd405;
	localparam logic [DIR_W-1:0] DIR_247P5 = 10'd495;
	localparam logic [DIR_W-1:0] DIR_292P5 = 10'd585;
	localparam logic [DIR_W-1:0] DIR_337P5 = 10'd675;

	typedef enum logic [1:0] {
		SEC_HORIZ  = 2'd0,
		SEC_DIAG_A = 2'd1,
		SEC_VERT   = 2'd2,
		SEC_DIAG_B = 2'd3
	} sector_t;

	typedef struct packed {
		logic [MAG_W-1:0] above;
		logic [MAG_W-1:0] middle;
		logic [DIR_W-1:0] dir;
	} line_word_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic eof;
	} pos_info_t;

	function automatic sector_t dir_sector(logic [DIR_W-1:0] d);
		sector_t s;
		s = SEC_HORIZ;
		priority if ((d >= DIR_22P5 && d < DIR_67P5) || (d >= DIR_202P5 && d < DIR_247P5)) begin
			s = SEC_DIAG_A;
		end else if ((d >= DIR_67P5 && d < DIR_112P5) ||
			(d >= DIR_247P5 && d < DIR_292P5)) begin
			s = SEC_VERT;
		end else if ((d >= DIR_112P5 && d < DIR_157P5) ||
			(d >= DIR_292P5 && d < DIR_337P5)) begin
			s = SEC_DIAG_B;
		end else begin
			s = SEC_HORIZ;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== src/nms_line_buf.sv =====
// Line memory holding the row above, the middle row and the middle-row direction.
`default_nettype none
module nms_line_buf #(
	parameter int MAX_WIDTH = nms_pkg::MAX_WIDTH_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire nms_pkg::line_word_t wr_data,
	output nms_pkg::line_word_t      rd_data
);

	nms_pkg::line_word_t mem [MAX_WIDTH];
	nms_pkg::line_word_t rd_q;
	nms_pkg::line_word_t byp_q;
	logic                byp_sel_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (rd_en && wr_en && rd_addr == wr_addr) begin
			byp_q <= wr_data;
		end
	end

	// forward a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_sel_q <= 1'b0;
		end else if (rd_en) begin
			byp_sel_q <= wr_en && (rd_addr == wr_addr);
		end
	end

	assign rd_data = byp_sel_q ? byp_q : rd_q;

endmodule
`default_nettype wire

// ===== src/nms_pos_ctrl.sv =====
// Frame geometry registers and raster position tracking for the NMS block.
`default_nettype none
module nms_pos_ctrl #(
	parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = nms_pkg::MAX_HEIGHT_DEF,
	localparam int AW = $clog2(MAX_WIDTH),
	localparam int RW = $clog2(MAX_HEIGHT + 2)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [nms_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [nms_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              advance,
	output logic [AW-1:0]                          col,
	output nms_pkg::pos_info_t                     info
);

	localparam int W_RST_M1 = ((nms_pkg::WIDTH_RST > MAX_WIDTH) ?
		MAX_WIDTH : nms_pkg::WIDTH_RST) - 1;
	localparam int H_RST_M1 = ((nms_pkg::HEIGHT_RST > MAX_HEIGHT) ?
		MAX_HEIGHT : nms_pkg::HEIGHT_RST) - 1;

	logic [AW-1:0] wm1_q;
	logic [RW-1:0] hm1_q;
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [31:0]   cfg_ext;
	logic [31:0]   w_sel;
	logic [31:0]   h_sel;
	logic [RW-1:0] orow;
	logic          ocol_zero;
	logic          ocol_last;
	logic          row_last;

	// clamp written geometry into the supported range, keep it as size minus one
	always_comb begin
		cfg_ext = 32'(cfg_data);
		if (cfg_ext < 32'(nms_pkg::MIN_DIM)) begin
			w_sel = 32'(nms_pkg::MIN_DIM - 1);
			h_sel = 32'(nms_pkg::MIN_DIM - 1);
		end else begin
			w_sel = (cfg_ext > 32'(MAX_WIDTH))  ? 32'(MAX_WIDTH - 1)  : cfg_ext - 32'd1;
			h_sel = (cfg_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT - 1) : cfg_ext - 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q <= AW'(W_RST_M1);
			hm1_q <= RW'(H_RST_M1);
		end else if (cfg_we) begin
			if (cfg_index == nms_pkg::REG_IMAGE_WIDTH) begin
				wm1_q <= w_sel[AW-1:0];
			end else if (cfg_index == nms_pkg::REG_IMAGE_HEIGHT) begin
				hm1_q <= h_sel[RW-1:0];
			end
		end
	end

	// the emitted pixel sits one row and one column behind the input
	always_comb begin
		orow      = row_q - ((col_q == '0) ? RW'(2) : RW'(1));
		ocol_zero = (col_q == AW'(1));
		ocol_last = (col_q == '0);
		row_last  = (orow >= hm1_q);
		info.emit   = (row_q >= RW'(2)) || (row_q == RW'(1) && col_q != '0);
		info.border = (orow == '0) || row_last || ocol_zero || ocol_last;
		info.eof    = row_last && ocol_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (info.emit && info.eof) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_q == wm1_q) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	assign col = col_q;

`ifndef ASSERT_OFF
	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0 && row_q == '0))
		else $error("configuration write did not restart the frame");
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wm1_q)
		else $error("column count ran past the row width");
`endif

endmodule
`default_nettype wire

// ===== src/nms_window.sv =====
// 3x3 magnitude window, direction sector stage and suppression compare.
`default_nettype none
module nms_window (
	input  wire logic                        clk,
	input  wire logic                        advance,
	input  wire logic [nms_pkg::MAG_W-1:0]   top,
	input  wire logic [nms_pkg::MAG_W-1:0]   mid,
	input  wire logic [nms_pkg::MAG_W-1:0]   mag,
	input  wire logic [nms_pkg::DIR_W-1:0]   dmid,
	input  wire logic                        border,
	output logic [nms_pkg::MAG_W-1:0]        pixel
);

	// columns zero and one of the window; column two comes straight from the inputs
	logic [nms_pkg::MAG_W-1:0] t1_q, t2_q, m1_q, m2_q, b1_q, b2_q;
	nms_pkg::sector_t          sec_q;
	logic [nms_pkg::MAG_W-1:0] nb_a, nb_b;

	always_ff @(posedge clk) begin
		if (advance) begin
			t1_q  <= t2_q;
			t2_q  <= top;
			m1_q  <= m2_q;
			m2_q  <= mid;
			b1_q  <= b2_q;
			b2_q  <= mag;
			sec_q <= nms_pkg::dir_sector(dmid);
		end
	end

	// neighbours as they stand after this shift; the center is m2_q
	always_comb begin
		unique case (sec_q)
			nms_pkg::SEC_DIAG_A: begin
				nb_a = top;
				nb_b = b1_q;
			end
			nms_pkg::SEC_VERT: begin
				nb_a = t2_q;
				nb_b = b2_q;
			end
			nms_pkg::SEC_DIAG_B: begin
				nb_a = t1_q;
				nb_b = mag;
			end
			default: begin
				nb_a = m1_q;
				nb_b = mid;
			end
		endcase
		if (!border && (nb_a > m2_q || nb_b > m2_q)) begin
			pixel = '0;
		end else begin
			pixel = m2_q;
		end
	end

endmodule
`default_nettype wire

// ===== src/gradient_non_maximum_suppression.sv =====
// Top level of the streaming 3x3 gradient non-maximum suppression block.
`default_nettype none
// Streaming Canny-style non-maximum suppression. Gradient pixels (8-bit
// magnitude, direction in half-degrees) enter in raster order, one per clock
// when in_ready is high, and the block returns the pixel one row and one
// column behind the input: an interior pixel is zeroed when either neighbour
// along its direction sector (horizontal, two diagonals, vertical) is larger,
// and border pixels pass unchanged. end_of_frame marks the bottom-right pixel.
// The first image_width+1 transactions of a frame give no output, so the
// source appends image_width+1 padding transactions after each frame to flush
// it. Throughput is one transaction per clock while the output is not stalled;
// a transaction that completes a pixel passes through stage 1 into the output
// register. The rate is set by the single line memory, which is read once
// when a transaction is accepted and written back when it leaves stage 1, with
// a forwarding path for the back-to-back access to column zero at a frame
// restart. An output register decouples the two sides, so input is still taken
// while a finished result waits, until the next result is ready to leave
// stage 1; that result then holds the input. Configuration writes
// (width, height) take effect at once, restart the frame position and must
// only be issued while the block is idle. There is no clearing pass: line
// entries never written only feed border pixels, which are not compared.
module gradient_non_maximum_suppression #(
	parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = nms_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [nms_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [nms_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [nms_pkg::MAG_W-1:0]         magnitude,
	input  wire logic [nms_pkg::DIR_W-1:0]         direction,
	input  wire logic                              is_padding,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [nms_pkg::MAG_W-1:0]              pixel_out,
	output logic                                   end_of_frame
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic                      accept;
	logic                      adv_s1;
	logic [AW-1:0]             col;
	nms_pkg::pos_info_t        info;

	// stage 1: memory read data arrives, window shifts, result is decided
	logic                      valid_s1;
	logic [nms_pkg::MAG_W-1:0] mag_s1;
	logic [nms_pkg::DIR_W-1:0] dir_s1;
	logic [AW-1:0]             col_s1;
	nms_pkg::pos_info_t        info_s1;

	nms_pkg::line_word_t       rd_word;
	nms_pkg::line_word_t       wr_word;
	logic [nms_pkg::MAG_W-1:0] win_pixel;

	logic                      out_valid_q;
	logic [nms_pkg::MAG_W-1:0] pixel_q;
	logic                      eof_q;

	// advance stage 1 unless it carries a result and the output register is blocked
	assign adv_s1   = valid_s1 && (!info_s1.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	nms_pos_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.col       (col),
		.info      (info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// padding pushes zero magnitude and direction into the stores
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1  <= is_padding ? '0 : magnitude;
			dir_s1  <= is_padding ? '0 : direction;
			col_s1  <= col;
			info_s1 <= info;
		end
	end

	// write back: middle row moves up, the new pixel becomes the middle row
	always_comb begin
		wr_word.above  = rd_word.middle;
		wr_word.middle = mag_s1;
		wr_word.dir    = dir_s1;
	end

	nms_line_buf #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data (wr_word),
		.rd_data (rd_word)
	);

	nms_window u_win (
		.clk     (clk),
		.advance (adv_s1),
		.top     (rd_word.above),
		.mid     (rd_word.middle),
		.mag     (mag_s1),
		.dmid    (rd_word.dir),
		.border  (info_s1.border),
		.pixel   (win_pixel)
	);

	// output register: load a result, drop valid once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && info_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && info_s1.emit) begin
			pixel_q <= win_pixel;
			eof_q   <= info_s1.eof;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = pixel_q;
	assign end_of_frame = eof_q;

`ifndef ASSERT_OFF
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled while the output register was free");
	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(col_s1) && $stable(mag_s1)))
		else $error("stage 1 lost its pixel during a stall");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && info_s1.emit) |=> out_valid_q)
		else $error("emitted pixel did not reach the output register");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the streaming gradient non-maximum suppression block.
module tb_top;

	localparam int CLK_PERIOD    = 8;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 700;
	localparam int MAX_REPORTS   = 10;
	localparam int IDLE_PCT      = 20;
	localparam int QUIET_W       = 12;
	localparam int QUIET_H       = 8;
	localparam int QUIET_FRAMES  = 2;
	// direction arithmetic in half-degrees
	localparam int FULL_TURN     = 720;
	localparam int HALF_TURN     = 360;
	localparam int DIR_MAX       = 1023;

	typedef logic [nms_pkg::MAG_W-1:0]      mag_t;
	typedef logic [nms_pkg::DIR_W-1:0]      dir_t;
	typedef logic [nms_pkg::CFG_DATA_W-1:0] cfg_word_t;

	typedef struct {
		mag_t mag;
		dir_t dir;
		logic pad;
	} grad_item_t;

	typedef struct {
		mag_t pixel;
		logic eof;
	} nms_pixel_t;

	logic                            clk        = 1'b0;
	logic                            arst_n     = 1'b0;
	logic                            cfg_we     = 1'b0;
	logic [nms_pkg::CFG_INDEX_W-1:0] cfg_index  = nms_pkg::REG_IMAGE_WIDTH;
	cfg_word_t                       cfg_data   = '0;
	logic                            in_valid   = 1'b0;
	mag_t                            magnitude  = '0;
	dir_t                            direction  = '0;
	logic                            is_padding = 1'b0;
	logic                            out_ready  = 1'b0;
	logic                            in_ready;
	logic                            out_valid;
	mag_t                            pixel_out;
	logic                            end_of_frame;

	gradient_non_maximum_suppression DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.magnitude    (magnitude),
		.direction    (direction),
		.is_padding   (is_padding),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_out    (pixel_out),
		.end_of_frame (end_of_frame)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Pending gradient transactions and the pixels they must produce.
	grad_item_t grad_items_q [$];
	nms_pixel_t expected_pixels [$];
	grad_item_t on_bus;

	// Shadow copy of the suppression state: line stores, 3x3 window, direction lag,
	// frame position and the two size registers.
	mag_t      mag_row_above [nms_pkg::MAX_WIDTH_DEF];
	mag_t      mag_row_mid   [nms_pkg::MAX_WIDTH_DEF];
	dir_t      dir_row_mid   [nms_pkg::MAX_WIDTH_DEF];
	mag_t      win [3][3];
	dir_t      dir_lag1, dir_lag2;
	int        col_pos, row_pos;
	cfg_word_t width_reg  = cfg_word_t'(nms_pkg::WIDTH_RST);
	cfg_word_t height_reg = cfg_word_t'(nms_pkg::HEIGHT_RST);

	bit quiet = 1'b0;
	int error_count, cycle_count, items_queued, items_accepted, pads_accepted;
	int pixels_checked, frames_seen, suppressed_count;

	function automatic int frame_width();
		int w;
		w = width_reg;
		if (w < nms_pkg::MIN_DIM) w = nms_pkg::MIN_DIM;
		if (w > nms_pkg::MAX_WIDTH_DEF) w = nms_pkg::MAX_WIDTH_DEF;
		return w;
	endfunction

	function automatic int frame_height();
		int h;
		h = height_reg;
		if (h < nms_pkg::MIN_DIM) h = nms_pkg::MIN_DIM;
		if (h > nms_pkg::MAX_HEIGHT_DEF) h = nms_pkg::MAX_HEIGHT_DEF;
		return h;
	endfunction

	// Fold the direction onto half a turn; anything past a full turn counts as horizontal.
	function automatic nms_pkg::sector_t dir_to_sector(dir_t d);
		int folded;
		if (d >= FULL_TURN) return nms_pkg::SEC_HORIZ;
		folded = (d >= HALF_TURN) ? d - HALF_TURN : d;
		if (folded < 45 || folded >= 315) return nms_pkg::SEC_HORIZ;
		if (folded < 135) return nms_pkg::SEC_DIAG_A;
		if (folded < 225) return nms_pkg::SEC_VERT;
		return nms_pkg::SEC_DIAG_B;
	endfunction

	// Keep the center only if neither neighbour along the sector is strictly larger.
	function automatic mag_t thin_center(nms_pkg::sector_t s);
		mag_t a, b, ctr;
		ctr = win[1][1];
		case (s)
			nms_pkg::SEC_DIAG_A: begin
				a = win[0][2];
				b = win[2][0];
			end
			nms_pkg::SEC_VERT: begin
				a = win[0][1];
				b = win[2][1];
			end
			nms_pkg::SEC_DIAG_B: begin
				a = win[0][0];
				b = win[2][2];
			end
			default: begin
				a = win[1][0];
				b = win[1][2];
			end
		endcase
		return (a > ctr || b > ctr) ? '0 : ctr;
	endfunction

	// Advance the shadow state by one accepted transaction and record any pixel it emits.
	task automatic predict_nms(input grad_item_t it);
		int w, h, c, r, orow, ocol;
		mag_t m, top, mid;
		dir_t d, dmid;
		nms_pixel_t px;
		w = frame_width();
		h = frame_height();
		c = col_pos;
		r = row_pos;
		m = it.pad ? '0 : it.mag;
		d = it.pad ? '0 : it.dir;
		if (c >= w) begin
			c = 0;
			r = 0;
		end
		top  = mag_row_above[c];
		mid  = mag_row_mid[c];
		dmid = dir_row_mid[c];
		mag_row_above[c] = mid;
		mag_row_mid[c]   = m;
		dir_row_mid[c]   = d;
		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = m;
		dir_lag2 = dir_lag1;
		dir_lag1 = dmid;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
		// nothing leaves until the window holds a full row plus one pixel
		if (!(r >= 2 || (r == 1 && c >= 1))) return;
		if (c >= 1) begin
			orow = r - 1;
			ocol = c - 1;
		end else begin
			orow = r - 2;
			ocol = w - 1;
		end
		if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
			px.pixel = win[1][1];
		end else begin
			px.pixel = thin_center(dir_to_sector(dir_lag2));
			if (px.pixel == 0 && win[1][1] != 0) suppressed_count++;
		end
		px.eof = (orow >= h - 1 && ocol >= w - 1);
		if (px.eof) begin
			col_pos = 0;
			row_pos = 0;
		end
		expected_pixels.push_back(px);
	endtask

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) $display("%s", msg);
	endtask

	// Driver: launch the next pending transaction when the slot frees up, idling at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_nms(on_bus);
				items_accepted++;
				if (on_bus.pad) pads_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (grad_items_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					on_bus = grad_items_q.pop_front();
					in_valid   <= 1'b1;
					magnitude  <= on_bus.mag;
					direction  <= on_bus.dir;
					is_padding <= on_bus.pad;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check every accepted pixel against the oldest expectation, stall at random.
	always @(posedge clk) begin
		nms_pixel_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					report_error($sformatf("unexpected pixel: pixel_out=%0d end_of_frame=%0b",
						pixel_out, end_of_frame));
				end else begin
					want = expected_pixels.pop_front();
					pixels_checked++;
					if (end_of_frame === 1'b1) frames_seen++;
					if (pixel_out !== want.pixel)
						report_error($sformatf("pixel %0d: pixel_out expected %0d got %0d",
							pixels_checked, want.pixel, pixel_out));
					if (end_of_frame !== want.eof)
						report_error($sformatf("pixel %0d: end_of_frame expected %0b got %0b",
							pixels_checked, want.eof, end_of_frame));
				end
			end
			out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic queue_item(input mag_t mag, input dir_t dir, input logic pad);
		grad_item_t it;
		it.mag = mag;
		it.dir = dir;
		it.pad = pad;
		grad_items_q.push_back(it);
		items_queued++;
	endtask

	// Bias directions toward the sector bounds, one step either side.
	function automatic dir_t pick_direction();
		int bounds [9] = '{45, 135, 225, 315, 405, 495, 585, 675, 720};
		if ($urandom_range(99) < 45) return dir_t'($urandom_range(DIR_MAX));
		return dir_t'(bounds[$urandom_range(8)] + $urandom_range(2) - 1);
	endfunction

	// Wait until the sender has nothing left and every expected pixel has come back.
	task automatic wait_drain();
		while (grad_items_q.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	// Drain, then give silent transactions time to leave the pipeline.
	task automatic settle();
		wait_drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Queue item_count transactions of the current frame: pixels, then flush padding.
	// noise_pct misplaces padding among pixels and pixels among padding.
	// pause_at holds the sender mid-frame until everything outstanding has returned.
	task automatic queue_frame(input int mag_max, input int noise_pct, input int item_count,
		input int pause_at);
		int pixel_count;
		pixel_count = frame_width() * frame_height();
		for (int i = 0; i < item_count; i++) begin
			if (i == pause_at) wait_drain();
			if (i < pixel_count)
				queue_item(mag_t'($urandom_range(mag_max)), pick_direction(),
					$urandom_range(99) < noise_pct);
			else
				queue_item(mag_t'($urandom_range(mag_max)), pick_direction(),
					$urandom_range(99) >= noise_pct);
		end
	endtask

	// One 3x3 frame with a chosen center direction, plus its flush.
	task automatic queue_tiny_frame(input mag_t mags [9], input dir_t center_dir);
		for (int i = 0; i < 9; i++)
			queue_item(mags[i], (i == 4) ? center_dir : dir_t'(719), 1'b0);
		// padding with live-looking fields that must be ignored
		for (int i = 0; i < 4; i++)
			queue_item('1, '1, 1'b1);
	endtask

	// Registers only move while the block is idle; each write restarts the frame position.
	task automatic write_reg(input logic [nms_pkg::CFG_INDEX_W-1:0] idx,
		input cfg_word_t value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == nms_pkg::REG_IMAGE_WIDTH) width_reg = value;
		else height_reg = value;
		col_pos = 0;
		row_pos = 0;
	endtask

	initial begin
		int w, h, kind, frames, full, base, phase;
		for (int i = 0; i < nms_pkg::MAX_WIDTH_DEF; i++) begin
			mag_row_above[i] = '0;
			mag_row_mid[i]   = '0;
			dir_row_mid[i]   = '0;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		dir_lag1 = '0;
		dir_lag2 = '0;
		col_pos  = 0;
		row_pos  = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes: run a partial 640-wide frame into its second row, hold the sender
		// mid-row until everything outstanding has returned, then abandon the frame.
		queue_frame(255, 0, nms_pkg::WIDTH_RST + 40, nms_pkg::WIDTH_RST + 20);
		settle();

		// Directed: out-of-range sizes clamp to 3x3, one interior pixel per frame.
		write_reg(nms_pkg::REG_IMAGE_WIDTH, cfg_word_t'(0));
		write_reg(nms_pkg::REG_IMAGE_HEIGHT, cfg_word_t'(2));
		// diagonal bound, larger up-right neighbour: zeroed
		queue_tiny_frame('{8'd10, 8'd10, 8'd255, 8'd10, 8'd100, 8'd10, 8'd10, 8'd10, 8'd10},
			dir_t'(45));
		// direction past a full turn reads as horizontal: vertical peaks do not matter
		queue_tiny_frame('{8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0},
			dir_t'(DIR_MAX));
		settle();

		// Random phases of small frames; sizes change only between phases.
		base  = items_queued;
		phase = 0;
		while (items_queued - base < RANDOM_ITEMS) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
			h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
			if (phase % 4 != 1) write_reg(nms_pkg::REG_IMAGE_WIDTH, cfg_word_t'(w));
			if (phase % 4 != 2) write_reg(nms_pkg::REG_IMAGE_HEIGHT, cfg_word_t'(h));
			frames = $urandom_range(1, 3);
			for (int f = 0; f < frames; f++) begin
				kind = $urandom_range(99);
				full = frame_width() * frame_height() + frame_width() + 1;
				if (kind < 6) begin
					// cut the frame short; the next register write restarts it
					queue_frame(255, 8, $urandom_range(1, full - 1), -1);
					break;
				end
				queue_frame((kind < 30) ? 3 : 255, (kind >= 85) ? 8 : 0, full,
					(phase == 0 && f == 0) ? full / 2 : -1);
			end
			settle();
			phase++;
		end

		// Back-to-back frames with no idling on either side.
		write_reg(nms_pkg::REG_IMAGE_WIDTH, cfg_word_t'(QUIET_W));
		write_reg(nms_pkg::REG_IMAGE_HEIGHT, cfg_word_t'(QUIET_H));
		quiet = 1'b1;
		full  = frame_width() * frame_height() + frame_width() + 1;
		for (int f = 0; f < QUIET_FRAMES; f++)
			queue_frame(255, 0, full, -1);
		settle();
		quiet = 1'b0;

		$display("summary: %0d transactions accepted (%0d padding), %0d pixels checked",
			items_accepted, pads_accepted, pixels_checked);
		$display("summary: %0d frames closed, %0d interior pixels thinned, %0d mismatches",
			frames_seen, suppressed_count, error_count);
		if (error_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
